// File: sv/jse_pkg.sv
// ----------------------------------------------------------------------------
// jse_pkg
// Shared types, constants and escape helpers for the JSON string escaper.
// ----------------------------------------------------------------------------
package jse_pkg;

  localparam int MAX_CAPACITY = 4096;
  localparam int CAP_W        = 13;
  localparam int ADDR_W       = 12;
  localparam int NEED_W       = 24;
  localparam int LEN_W        = 3;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QUEUE_AW     = 2;
  localparam int QUEUE_CW     = 3;

  localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(MAX_CAPACITY);
  localparam logic [NEED_W-1:0] NEED_MAX  = {NEED_W{1'b1}};

  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_FF       = 8'h0C;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_CTRL_TOP = 8'h20;
  localparam logic [7:0] CH_LOW_B    = 8'h62;
  localparam logic [7:0] CH_LOW_F    = 8'h66;
  localparam logic [7:0] CH_LOW_N    = 8'h6E;
  localparam logic [7:0] CH_LOW_R    = 8'h72;
  localparam logic [7:0] CH_LOW_T    = 8'h74;
  localparam logic [7:0] CH_LOW_U    = 8'h75;
  localparam logic [7:0] CH_LOW_A    = 8'h61;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NUL      = 8'h00;

  typedef enum logic [1:0] {
    KIND_PLAIN,
    KIND_SHORT,
    KIND_UNI,
    KIND_TERM
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         data;
    logic               store;
    logic [ADDR_W-1:0]  base;
    logic [NEED_W-1:0]  needed;
  } desc_t;

  function automatic logic [LEN_W-1:0] seq_len(input kind_t kind);
    logic [LEN_W-1:0] len;
    unique case (kind)
      KIND_SHORT: len = LEN_W'(2);
      KIND_UNI:   len = LEN_W'(6);
      default:    len = LEN_W'(1);
    endcase
    return len;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) ch = CH_ZERO + {4'd0, nib};
    else ch = CH_LOW_A + {4'd0, nib} - 8'd10;
    return ch;
  endfunction

  function automatic logic [7:0] seq_byte(input desc_t d, input logic [LEN_W-1:0] k);
    logic [7:0] ch;
    ch = CH_NUL;
    unique case (d.kind)
      KIND_PLAIN: ch = d.data;
      KIND_SHORT: ch = (k == '0) ? CH_BSLASH : d.data;
      KIND_UNI: begin
        case (k)
          3'd0:    ch = CH_BSLASH;
          3'd1:    ch = CH_LOW_U;
          3'd2:    ch = CH_ZERO;
          3'd3:    ch = CH_ZERO;
          3'd4:    ch = hex_digit(d.data[7:4]);
          default: ch = hex_digit(d.data[3:0]);
        endcase
      end
      default:    ch = CH_NUL;
    endcase
    return ch;
  endfunction

endpackage

// File: sv/jse_front.sv
// ----------------------------------------------------------------------------
// jse_front
// Accepts input words, classifies the escape and keeps the length counters.
// ----------------------------------------------------------------------------
module jse_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [12:0]          cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           char_in,
  input  logic                 is_end,
  input  logic                 q_full,
  output logic                 q_push,
  output jse_pkg::desc_t       q_desc
);
  import jse_pkg::*;

  logic [CAP_W-1:0]  capacity;
  logic [CAP_W-1:0]  written_count;
  logic [CAP_W-1:0]  written_count_next;
  logic [NEED_W-1:0] needed_total;
  logic [NEED_W-1:0] needed_total_next;

  logic [CAP_W-1:0]  cap_eff;
  kind_t             kind;
  logic [7:0]        data;
  logic [LEN_W-1:0]  len;
  logic [CAP_W:0]    span;
  logic              fits;
  logic [NEED_W:0]   need_sum;
  logic [NEED_W-1:0] need_sat;
  logic              term_store;
  logic [CAP_W-1:0]  term_addr;

  assign cap_eff = (capacity > CAP_W'(MAX_CAPACITY)) ? CAP_W'(MAX_CAPACITY) : capacity;

  always_comb begin
    data = char_in;
    unique case (char_in) inside
      CH_QUOTE, CH_BSLASH: kind = KIND_SHORT;
      CH_BS:  begin kind = KIND_SHORT; data = CH_LOW_B; end
      CH_FF:  begin kind = KIND_SHORT; data = CH_LOW_F; end
      CH_LF:  begin kind = KIND_SHORT; data = CH_LOW_N; end
      CH_CR:  begin kind = KIND_SHORT; data = CH_LOW_R; end
      CH_TAB: begin kind = KIND_SHORT; data = CH_LOW_T; end
      default: kind = (char_in < CH_CTRL_TOP) ? KIND_UNI : KIND_PLAIN;
    endcase
  end

  assign len      = seq_len(kind);
  assign span     = {1'b0, written_count} + (CAP_W+1)'(len) + (CAP_W+1)'(1);
  assign fits     = span <= {1'b0, cap_eff};
  assign need_sum = {1'b0, needed_total} + (NEED_W+1)'(len);
  assign need_sat = need_sum[NEED_W] ? NEED_MAX : need_sum[NEED_W-1:0];

  assign term_store = cap_eff != '0;

  always_comb begin
    if (!term_store) term_addr = '0;
    else if (written_count >= cap_eff) term_addr = cap_eff - CAP_W'(1);
    else term_addr = written_count;
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    if (is_end) begin
      q_desc.kind   = KIND_TERM;
      q_desc.data   = CH_NUL;
      q_desc.store  = term_store;
      q_desc.base   = term_addr[ADDR_W-1:0];
      q_desc.needed = needed_total;
    end else begin
      q_desc.kind   = kind;
      q_desc.data   = data;
      q_desc.store  = fits;
      q_desc.base   = written_count[ADDR_W-1:0];
      q_desc.needed = need_sat;
    end
  end

  always_comb begin
    written_count_next = written_count;
    needed_total_next  = needed_total;
    if (q_push) begin
      if (is_end) begin
        written_count_next = '0;
        needed_total_next  = '0;
      end else begin
        if (fits) written_count_next = written_count + CAP_W'(len);
        needed_total_next = need_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity      <= CAP_RESET;
      written_count <= '0;
      needed_total  <= '0;
    end else begin
      if (cfg_we) capacity <= cfg_wdata;
      written_count <= written_count_next;
      needed_total  <= needed_total_next;
    end
  end

endmodule

// File: sv/jse_queue.sv
// ----------------------------------------------------------------------------
// jse_queue
// Short descriptor queue between the classifier and the expander.
// ----------------------------------------------------------------------------
module jse_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  jse_pkg::desc_t  push_desc,
  input  logic            pop,
  output logic            full,
  output logic            head_valid,
  output jse_pkg::desc_t  head_desc
);
  import jse_pkg::*;

  desc_t                slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wptr;
  logic [QUEUE_AW-1:0]  rptr;
  logic [QUEUE_CW-1:0]  count;

  assign full       = count == QUEUE_CW'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_desc  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_desc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + QUEUE_AW'(1);
      if (pop)  rptr <= rptr + QUEUE_AW'(1);
      case ({push, pop})
        2'b10:   count <= count + QUEUE_CW'(1);
        2'b01:   count <= count - QUEUE_CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: sv/jse_back.sv
// ----------------------------------------------------------------------------
// jse_back
// Expands one descriptor into its escape bytes behind an output register.
// ----------------------------------------------------------------------------
module jse_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  jse_pkg::desc_t  head_desc,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_byte,
  output logic            store,
  output logic [11:0]     store_addr,
  output logic            run_last,
  output logic            is_terminator,
  output logic [23:0]     needed_count
);
  import jse_pkg::*;

  logic [LEN_W-1:0] idx;
  logic             load;
  logic             take;
  logic             last;

  assign load = !out_valid || !out_stall;
  assign take = head_valid && load;
  assign last = idx == seq_len(head_desc.kind) - LEN_W'(1);
  assign pop  = take && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) out_valid <= head_valid;
      if (take) idx <= last ? '0 : idx + LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_byte      <= seq_byte(head_desc, idx);
      store         <= head_desc.store;
      store_addr    <= head_desc.store ? head_desc.base + ADDR_W'(idx) : '0;
      run_last      <= last;
      is_terminator <= head_desc.kind == KIND_TERM;
      needed_count  <= head_desc.needed;
    end
  end

endmodule

// File: sv/json_string_escaper_core.sv
// ----------------------------------------------------------------------------
// json_string_escaper_core
// JSON string escaper: raw bytes in, escaped bytes with buffer addresses out.
// ----------------------------------------------------------------------------
// Each input word is one raw byte or an end mark. Plain bytes leave one output
// word, quote, backslash and the five short controls leave two, other controls
// leave six (\u00xx); the end mark leaves the NUL terminator with the final
// needed length and clears the counters. The input side takes one word per
// cycle while the four-entry descriptor queue has room; the output register
// emits one word per cycle while out_stall is low. Each input word is written
// into the queue and then expanded into the output register. Capacity
// (cfg_we/cfg_wdata, reset 4096, values above 4096 act as 4096) must be
// written only while the block is idle; the block itself does not enforce it.
module json_string_escaper_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_in,
  input  logic        is_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        store,
  output logic [11:0] store_addr,
  output logic        run_last,
  output logic        is_terminator,
  output logic [23:0] needed_count
);
  import jse_pkg::*;

  logic  q_full;
  logic  q_push;
  desc_t q_desc;
  logic  q_pop;
  logic  head_valid;
  desc_t head_desc;

  jse_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_in   (char_in),
    .is_end    (is_end),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_desc    (q_desc)
  );

  jse_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_desc  (q_desc),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_desc  (head_desc)
  );

  jse_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_desc     (head_desc),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .store         (store),
    .store_addr    (store_addr),
    .run_last      (run_last),
    .is_terminator (is_terminator),
    .needed_count  (needed_count)
  );

endmodule

// File: sv/jse_checker.sv
// ----------------------------------------------------------------------------
// jse_checker
// Port-level checks for the JSON string escaper.
// ----------------------------------------------------------------------------
module jse_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_byte,
  input logic        store,
  input logic [11:0] store_addr,
  input logic        run_last,
  input logic        is_terminator,
  input logic [23:0] needed_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(store_addr))
    else $error("stalled output word changed");

  a_term_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_terminator |-> out_byte == 8'h00 && run_last)
    else $error("terminator word malformed");

  a_skip_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && !store |-> store_addr == 12'h000)
    else $error("skipped word carries an address");

  a_seq_cont: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !run_last |=>
      out_valid && $stable(needed_count) && (store_addr == $past(store_addr) + 12'h001
      || !store))
    else $error("escape sequence broken");

endmodule

bind json_string_escaper_core jse_checker u_jse_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_byte      (out_byte),
  .store         (store),
  .store_addr    (store_addr),
  .run_last      (run_last),
  .is_terminator (is_terminator),
  .needed_count  (needed_count)
);

// File: tb/sv/tb_json_string_escaper_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_json_string_escaper_core
// Self-checking bench: random strings are pushed through the escaper under
// random input gaps and output stalls, across several buffer capacities. Each
// accepted word is expanded by a local escape predictor into the escaped words
// it should leave, and every output word is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_json_string_escaper_core;
  import jse_pkg::*;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    logic       hold;
  } raw_word_t;

  typedef struct {
    logic [7:0]        data;
    logic              st;
    logic [ADDR_W-1:0] addr;
    logic              last;
    logic              term;
    logic [NEED_W-1:0] need;
  } esc_word_t;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int TAIL_CYCLES     = 16;
  localparam int RANDOM_ITEMS    = 145;
  localparam logic [8*16-1:0] HEX_CHARS = "0123456789abcdef";

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [CAP_W-1:0]  cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        char_in = '0;
  logic              is_end = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [7:0]        out_byte;
  logic              store;
  logic [ADDR_W-1:0] store_addr;
  logic              run_last;
  logic              is_terminator;
  logic [NEED_W-1:0] needed_count;

  raw_word_t pending_chars[$];
  esc_word_t escaped_words[$];

  logic [CAP_W-1:0]  cap_copy = CAP_RESET;
  int                stored_count = 0;
  logic [NEED_W-1:0] need_total = '0;

  int mismatches = 0;
  int quiet_cycles = 0;
  int gap_left = 0;
  int stall_left = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int queued_total = 0;

  json_string_escaper_core u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .char_in      (char_in),
    .is_end       (is_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .store        (store),
    .store_addr   (store_addr),
    .run_last     (run_last),
    .is_terminator(is_terminator),
    .needed_count (needed_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic escape_char(input logic [7:0] ch, input logic term);
    esc_word_t  r;
    kind_t      kind;
    logic [7:0] seq [6];
    int         n, room, base;
    logic       fits;
    room = (int'(cap_copy) > MAX_CAPACITY) ? MAX_CAPACITY : int'(cap_copy);
    if (term) begin
      r.data = CH_NUL;
      r.st   = (room > 0);
      if (room == 0) r.addr = '0;
      else if (stored_count >= room) r.addr = ADDR_W'(room - 1);
      else r.addr = ADDR_W'(stored_count);
      r.last = 1'b1;
      r.term = 1'b1;
      r.need = need_total;
      escaped_words.push_back(r);
      stored_count = 0;
      need_total = '0;
    end else begin
      kind = KIND_SHORT;
      seq[0] = CH_BSLASH;
      case (ch)
        CH_QUOTE, CH_BSLASH: seq[1] = ch;
        CH_BS:  seq[1] = CH_LOW_B;
        CH_FF:  seq[1] = CH_LOW_F;
        CH_LF:  seq[1] = CH_LOW_N;
        CH_CR:  seq[1] = CH_LOW_R;
        CH_TAB: seq[1] = CH_LOW_T;
        default: begin
          if (ch < CH_CTRL_TOP) begin
            kind = KIND_UNI;
            seq[1] = CH_LOW_U;
            seq[2] = CH_ZERO;
            seq[3] = CH_ZERO;
            seq[4] = HEX_CHARS[8*(15 - int'(ch[7:4])) +: 8];
            seq[5] = HEX_CHARS[8*(15 - int'(ch[3:0])) +: 8];
          end else begin
            kind = KIND_PLAIN;
            seq[0] = ch;
          end
        end
      endcase
      case (kind)
        KIND_SHORT: n = 2;
        KIND_UNI:   n = 6;
        default:    n = 1;
      endcase
      base = stored_count;
      fits = (base + n + 1 <= room);
      if (fits) stored_count = base + n;
      if (int'(need_total) + n > int'(NEED_MAX)) need_total = NEED_MAX;
      else need_total = need_total + NEED_W'(n);
      for (int k = 0; k < n; k++) begin
        r.data = seq[k];
        r.st   = fits;
        r.addr = fits ? ADDR_W'(base + k) : '0;
        r.last = (k == n - 1);
        r.term = 1'b0;
        r.need = need_total;
        escaped_words.push_back(r);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // Check outputs, predict accepted input words, watch for a hang.
  always @(posedge clk) begin
    esc_word_t e;
    if (rst) begin
      cap_copy = CAP_RESET;
      stored_count = 0;
      need_total = '0;
      quiet_cycles = 0;
    end else begin
      if (cfg_we) cap_copy = cfg_wdata;
      if (out_valid && !out_stall) begin
        if (escaped_words.size() == 0) begin
          mismatches++;
          $display("%0t ns: unexpected word, expected none actual out_byte %0h",
                   $time, out_byte);
        end else begin
          e = escaped_words.pop_front();
          check_field("out_byte", 32'(e.data), 32'(out_byte));
          check_field("store", 32'(e.st), 32'(store));
          check_field("store_addr", 32'(e.addr), 32'(store_addr));
          check_field("run_last", 32'(e.last), 32'(run_last));
          check_field("is_terminator", 32'(e.term), 32'(is_terminator));
          check_field("needed_count", 32'(e.need), 32'(needed_count));
        end
      end
      if (in_valid && !in_stall) escape_char(char_in, is_end);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
          $display("FAIL json_string_escaper_core");
          $finish;
        end
      end
    end
  end

  // Input driver: hold a stalled word, otherwise idle or advance.
  always @(posedge clk) begin
    raw_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_chars.size() == 0) begin
        in_valid <= 1'b0;
      end else if (pending_chars[0].hold &&
                   (escaped_words.size() != 0 || in_valid)) begin
        in_valid <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        gap_left = $urandom_range(0, 14);
        in_valid <= 1'b0;
      end else begin
        w = pending_chars.pop_front();
        in_valid <= 1'b1;
        char_in <= w.ch;
        is_end <= w.last;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, 14);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic queue_word(input logic [7:0] ch, input logic last, input logic hold);
    raw_word_t w;
    w.ch = ch;
    w.last = last;
    w.hold = hold;
    pending_chars.push_back(w);
    queued_total++;
  endtask

  function automatic logic [7:0] random_char();
    logic [7:0] ch;
    case ($urandom_range(0, 9))
      6, 7: begin
        case ($urandom_range(0, 6))
          0: ch = CH_QUOTE;
          1: ch = CH_BSLASH;
          2: ch = CH_BS;
          3: ch = CH_FF;
          4: ch = CH_LF;
          5: ch = CH_CR;
          default: ch = CH_TAB;
        endcase
      end
      8, 9: ch = 8'($urandom_range(0, 31));
      default: ch = 8'($urandom_range(32, 255));
    endcase
    return ch;
  endfunction

  task automatic queue_string(input int len);
    for (int k = 0; k < len; k++) queue_word(random_char(), 1'b0, $urandom_range(0, 24) == 0);
    queue_word(8'($urandom_range(0, 255)), 1'b1, 1'b0);
  endtask

  task automatic drain_out();
    do @(negedge clk);
    while (pending_chars.size() != 0 || in_valid || escaped_words.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] value);
    drain_out();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    idle_pct = 15;
    stall_pct = 15;

    queue_word(CH_CTRL_TOP, 1'b0, 1'b0);
    queue_word(8'h7F, 1'b0, 1'b0);
    queue_word(8'h80, 1'b0, 1'b0);
    queue_word(8'hFF, 1'b0, 1'b0);
    queue_word(CH_QUOTE, 1'b0, 1'b0);
    queue_word(CH_BSLASH, 1'b0, 1'b0);
    queue_word(CH_BS, 1'b0, 1'b0);
    queue_word(CH_FF, 1'b0, 1'b0);
    queue_word(CH_LF, 1'b0, 1'b1);
    queue_word(CH_CR, 1'b0, 1'b0);
    queue_word(CH_TAB, 1'b0, 1'b0);
    queue_word(CH_NUL, 1'b0, 1'b0);
    queue_word(8'h1F, 1'b0, 1'b0);
    queue_word(8'h01, 1'b0, 1'b0);
    queue_word(8'h10, 1'b0, 1'b0);
    queue_word(8'hA5, 1'b1, 1'b0);

    set_capacity(CAP_W'(8191));
    queue_word(8'h55, 1'b0, 1'b0);
    queue_word(8'h1E, 1'b0, 1'b0);
    queue_word(8'hFF, 1'b1, 1'b0);

    set_capacity('0);
    queue_word(CH_QUOTE, 1'b0, 1'b0);
    queue_word(8'h61, 1'b0, 1'b0);
    queue_word(8'h00, 1'b1, 1'b0);

    set_capacity(CAP_W'(5));
    queue_word(8'h61, 1'b0, 1'b0);
    queue_word(8'h62, 1'b0, 1'b0);
    queue_word(8'h03, 1'b0, 1'b0);
    queue_word(8'h63, 1'b0, 1'b0);
    queue_word(8'h5A, 1'b1, 1'b0);

    // Lower the capacity below the stored count before the end mark.
    set_capacity(CAP_RESET);
    repeat (8) queue_word(random_char(), 1'b0, 1'b0);
    set_capacity(CAP_W'(3));
    queue_word(8'($urandom_range(0, 255)), 1'b1, 1'b0);

    queued_total = 0;
    while (queued_total < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0: set_capacity('0);
        1: set_capacity(CAP_W'($urandom_range(1, 3)));
        2: set_capacity(CAP_W'($urandom_range(4, 40)));
        3: set_capacity(CAP_W'($urandom_range(41, 200)));
        4: set_capacity(CAP_RESET);
        default: set_capacity(CAP_W'($urandom_range(4097, 8191)));
      endcase
      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 10;
        default: idle_pct = 40;
      endcase
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 10;
        default: stall_pct = 40;
      endcase
      repeat ($urandom_range(1, 4)) queue_string($urandom_range(0, 14));
    end

    idle_pct = 0;
    stall_pct = 0;
    set_capacity(CAP_RESET);
    repeat (2) queue_string($urandom_range(8, 12));
    drain_out();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASS json_string_escaper_core");
    end else begin
      $display("FAIL json_string_escaper_core");
    end
    $finish;
  end

endmodule
